/* rtl/tdra_pkg.sv */
// ----------------------------------------------------------------------------
// Region allocator package
// Shared widths, constants, status codes and the slot record carried around
// the ring of slot cells.
// ----------------------------------------------------------------------------
package tdra_pkg;

	// Sizing of the slot ring and the page granule (a power of two).
	localparam int SLOT_COUNT = 16;
	localparam int PAGE_BYTES = 4096;

	// Field widths.
	localparam int ADDR_W   = 38;
	localparam int LEN_IN_W = 32;
	localparam int LEN_W    = 31;
	localparam int RND_W    = 32;
	localparam int PROT_W   = 3;
	localparam int FLAGS_W  = 2;
	localparam int OFFS_W   = 32;
	localparam int FILE_W   = 7;
	localparam int SLOT_W   = 4;
	localparam int STATUS_W = 2;

	// Ring position and pass counter widths.
	localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int PASS_W = $clog2(SLOT_COUNT + 1);

	// Reset value of the upper end of the placement area.
	localparam logic [ADDR_W-1:0] TOP_RESET = 38'd274877898752;

	// Low bits that are rounded away to reach a page boundary.
	localparam logic [RND_W-1:0] PAGE_MASK = RND_W'(PAGE_BYTES - 1);

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_GRANT   = 2'd0,
		ST_BAD_ARG = 2'd1,
		ST_NO_SLOT = 2'd2,
		ST_NO_ROOM = 2'd3
	} status_t;

	// Contents of one slot.
	typedef struct packed {
		logic [ADDR_W-1:0]  slot_start;
		logic [LEN_W-1:0]   slot_length;
		logic [PROT_W-1:0]  slot_protection;
		logic [FLAGS_W-1:0] slot_flags;
		logic [OFFS_W-1:0]  slot_offset;
		logic [FILE_W-1:0]  slot_file;
	} slot_rec_t;

	// Ring control from the sequencer to the cells.
	typedef struct packed {
		logic             shift;
		logic             load;
		logic [IDX_W-1:0] idx;
	} ring_ctl_t;

endpackage

/* rtl/tdra_cell.sv */
// ----------------------------------------------------------------------------
// Slot cell
// Holds one slot record. While the ring turns it takes the record of its
// neighbor; when selected for a grant it takes the new record instead.
// ----------------------------------------------------------------------------
module tdra_cell (
	input  logic                clk,
	input  logic                shift,
	input  logic                load,
	input  tdra_pkg::slot_rec_t nbr_rec,
	input  tdra_pkg::slot_rec_t new_rec,
	output tdra_pkg::slot_rec_t rec
);
	import tdra_pkg::*;

	slot_rec_t rec_q;

	// A grant write wins over the ring shift; the two never coincide.
	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= new_rec;
		end else if (shift) begin
			rec_q <= nbr_rec;
		end
	end

	assign rec = rec_q;

endmodule

/* rtl/tdra_ctrl.sv */
// ----------------------------------------------------------------------------
// Allocator sequencer
// Checks the request, rounds the length, then scans the slot ring one record
// per cycle with a single overlap comparator, moving the candidate below a used
// region it meets and running another pass, and finally records the grant.
// ----------------------------------------------------------------------------
module tdra_ctrl (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [tdra_pkg::LEN_IN_W-1:0]  request_length,
	input  logic        [tdra_pkg::PROT_W-1:0]    protection,
	input  logic        [tdra_pkg::FLAGS_W-1:0]   map_flags,
	input  logic signed [tdra_pkg::OFFS_W-1:0]    file_offset,
	input  logic        [tdra_pkg::FILE_W-1:0]    file_id,
	input  logic                                  file_valid,
	input  logic        [tdra_pkg::ADDR_W-1:0]    top_address,
	input  tdra_pkg::slot_rec_t                   head_rec,
	output logic                                  busy,
	output logic                                  done,
	output logic        [tdra_pkg::STATUS_W-1:0]  status,
	output logic        [tdra_pkg::ADDR_W-1:0]    region_address,
	output logic        [tdra_pkg::SLOT_W-1:0]    slot_index,
	output tdra_pkg::ring_ctl_t                   ring_ctl,
	output tdra_pkg::slot_rec_t                   new_rec
);
	import tdra_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_PREP  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_WRITE = 4'b1000
	} fsm_t;

	fsm_t                  state_q;
	logic [SLOT_COUNT-1:0] in_use_q;
	logic [IDX_W-1:0]      phase_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic [IDX_W-1:0]      free_idx;
	logic                  free_found;
	logic [PASS_W-1:0]     pass_q;
	logic                  moved_q;
	logic                  abort_q;
	logic [RND_W-1:0]      rounded_q;
	logic [RND_W-1:0]      rounded_in;
	logic [ADDR_W-1:0]     rounded_ext;
	logic [ADDR_W-1:0]     addr_q;
	logic [ADDR_W-1:0]     addr_end_q;
	slot_rec_t             req_q;
	logic                  accept;
	logic                  arg_bad;
	logic [ADDR_W:0]       slot_end;
	logic                  hit;
	logic                  fits_below;
	logic                  last_slot;
	logic                  moved_now;
	logic                  abort_now;
	logic                  done_next;
	logic                  done_q;
	status_t               res_status_q;
	logic [ADDR_W-1:0]     res_addr_q;
	logic [SLOT_W-1:0]     res_slot_q;

	// Handshake and argument checks.
	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign arg_bad = (request_length <= 32'sd0) || !file_valid;

	// Round the length up to a whole page.
	assign rounded_in  = (RND_W'(unsigned'(request_length)) + PAGE_MASK) & ~PAGE_MASK;
	assign rounded_ext = {{(ADDR_W-RND_W){1'b0}}, rounded_q};

	// Lowest-numbered free slot.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// Overlap test of the candidate against the record at the head of the ring.
	assign slot_end   = {1'b0, head_rec.slot_start}
		+ {{(ADDR_W+1-LEN_W){1'b0}}, head_rec.slot_length};
	assign hit        = !(moved_q || abort_q) && in_use_q[phase_q]
		&& ({1'b0, addr_q} < slot_end) && (addr_end_q > head_rec.slot_start);
	assign fits_below = (head_rec.slot_start >= rounded_ext);
	assign last_slot  = (phase_q == IDX_W'(SLOT_COUNT - 1));
	assign moved_now  = moved_q || (hit && fits_below);
	assign abort_now  = abort_q || (hit && !fits_below);

	// Result strobe: raised in the cycle after each state that ends a request.
	always_comb begin
		case (state_q)
			S_IDLE:  done_next = accept && (arg_bad || !free_found);
			S_PREP:  done_next = (rounded_ext > top_address);
			S_SCAN:  done_next = last_slot && abort_now;
			S_WRITE: done_next = 1'b1;
			default: done_next = 1'b0;
		endcase
	end

	// Ring control: turn during the scan, write the free slot on a grant.
	assign ring_ctl.shift = (state_q == S_SCAN);
	assign ring_ctl.load  = (state_q == S_WRITE);
	assign ring_ctl.idx   = free_idx_q;

	// New record for the granted slot.
	always_comb begin
		new_rec            = req_q;
		new_rec.slot_start = addr_q;
	end

	// Sequencer and slot occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			in_use_q <= '0;
			phase_q  <= '0;
			pass_q   <= '0;
			moved_q  <= 1'b0;
			abort_q  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= done_next;
			case (state_q)
				S_IDLE: begin
					if (accept && !arg_bad && free_found) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (rounded_ext > top_address) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
						phase_q <= '0;
						pass_q  <= '0;
						moved_q <= 1'b0;
						abort_q <= 1'b0;
					end
				end
				S_SCAN: begin
					phase_q <= last_slot ? '0 : phase_q + 1'b1;
					// At the end of a pass the ring is back in slot order.
					if (last_slot) begin
						if (abort_now) begin
							state_q <= S_IDLE;
						end else if (moved_now && (pass_q != PASS_W'(SLOT_COUNT))) begin
							pass_q  <= pass_q + 1'b1;
							moved_q <= 1'b0;
						end else begin
							state_q <= S_WRITE;
						end
					end else if (hit) begin
						if (fits_below) begin
							moved_q <= 1'b1;
						end else begin
							abort_q <= 1'b1;
						end
					end
				end
				S_WRITE: begin
					in_use_q[free_idx_q] <= 1'b1;
					state_q              <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request, candidate and result words.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_status_q          <= arg_bad ? ST_BAD_ARG : ST_NO_SLOT;
					res_addr_q            <= '0;
					res_slot_q            <= '0;
					rounded_q             <= rounded_in;
					free_idx_q            <= free_idx;
					req_q.slot_start      <= '0;
					req_q.slot_length     <= request_length[LEN_W-1:0];
					req_q.slot_protection <= protection;
					req_q.slot_flags      <= map_flags;
					req_q.slot_offset     <= file_offset;
					req_q.slot_file       <= file_id;
				end
			end
			S_PREP: begin
				res_status_q <= ST_NO_ROOM;
				res_addr_q   <= '0;
				res_slot_q   <= '0;
				addr_q       <= top_address - rounded_ext;
				addr_end_q   <= top_address;
			end
			S_SCAN: begin
				// Move the candidate just below the region it overlaps.
				if (hit && fits_below) begin
					addr_q     <= head_rec.slot_start - rounded_ext;
					addr_end_q <= head_rec.slot_start;
				end
			end
			S_WRITE: begin
				res_status_q <= ST_GRANT;
				res_addr_q   <= addr_q;
				res_slot_q   <= SLOT_W'(free_idx_q);
			end
			default: begin
				res_status_q <= ST_NO_ROOM;
			end
		endcase
	end

	assign done           = done_q;
	assign status         = res_status_q;
	assign region_address = res_addr_q;
	assign slot_index     = res_slot_q;

endmodule

/* rtl/top_down_region_allocator_top.sv */
// ----------------------------------------------------------------------------
// Top-down region allocator
// Places each requested region below a programmable top address, first fit
// from the top, and records it in a free slot of a ring of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive the request word and raise start; it is taken at a
//   rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with status,
//   region_address and slot_index. The receiver cannot stall it.
//   Configuration: cfg_we writes cfg_wdata into the top address at the edge.
//   Sequence: a bad argument or a full slot table is answered in the cycle after
//   the word is taken. Otherwise the word passes through a prepare state, P scan
//   passes (P from 1 to SLOT_COUNT + 1) and a write state before a grant; out of
//   room found in a pass ends after that pass, an early out of room after prepare.
//   Throughput: one word at a time; the ring of SLOT_COUNT cells turns past a
//   single overlap comparator once per pass. busy is low again in the cycle
//   that shows done.
//   Reset: all slots are free, the top address returns to its reset value,
//   and the block is idle at once.
// ----------------------------------------------------------------------------
module top_down_region_allocator_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [tdra_pkg::LEN_IN_W-1:0]  request_length,
	input  logic        [tdra_pkg::PROT_W-1:0]    protection,
	input  logic        [tdra_pkg::FLAGS_W-1:0]   map_flags,
	input  logic signed [tdra_pkg::OFFS_W-1:0]    file_offset,
	input  logic        [tdra_pkg::FILE_W-1:0]    file_id,
	input  logic                                  file_valid,
	output logic                                  done,
	output logic        [tdra_pkg::STATUS_W-1:0]  status,
	output logic        [tdra_pkg::ADDR_W-1:0]    region_address,
	output logic        [tdra_pkg::SLOT_W-1:0]    slot_index,
	input  logic                                  cfg_we,
	input  logic        [tdra_pkg::ADDR_W-1:0]    cfg_wdata
);
	import tdra_pkg::*;

	logic [ADDR_W-1:0] top_q;
	ring_ctl_t         ring_ctl;
	slot_rec_t         new_rec;
	slot_rec_t         rec [SLOT_COUNT];

	// Top address register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= TOP_RESET;
		end else if (cfg_we) begin
			top_q <= cfg_wdata;
		end
	end

	// Ring of slot cells; cell 0 is the head seen by the comparator.
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		tdra_cell u_cell (
			.clk     (clk),
			.shift   (ring_ctl.shift),
			.load    (ring_ctl.load && (ring_ctl.idx == IDX_W'(i))),
			.nbr_rec (rec[(i + 1) % SLOT_COUNT]),
			.new_rec (new_rec),
			.rec     (rec[i])
		);
	end

	// Sequencer with the overlap comparator.
	tdra_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.request_length (request_length),
		.protection     (protection),
		.map_flags      (map_flags),
		.file_offset    (file_offset),
		.file_id        (file_id),
		.file_valid     (file_valid),
		.top_address    (top_q),
		.head_rec       (rec[0]),
		.busy           (busy),
		.done           (done),
		.status         (status),
		.region_address (region_address),
		.slot_index     (slot_index),
		.ring_ctl       (ring_ctl),
		.new_rec        (new_rec)
	);

endmodule

/* rtl/tdra_checker.sv */
// ----------------------------------------------------------------------------
// Region allocator port checker
// Watches the top-level ports for request and result word consistency.
// ----------------------------------------------------------------------------
module tdra_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  start,
	input logic                                  busy,
	input logic signed [tdra_pkg::LEN_IN_W-1:0]  request_length,
	input logic                                  file_valid,
	input logic                                  done,
	input logic        [tdra_pkg::STATUS_W-1:0]  status,
	input logic        [tdra_pkg::ADDR_W-1:0]    region_address,
	input logic        [tdra_pkg::SLOT_W-1:0]    slot_index
);
	import tdra_pkg::*;

	// A refused word carries a zero address and slot.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_GRANT)) |-> (region_address == '0 && slot_index == '0))
		else $error("refused word with nonzero address or slot");

	// A bad argument is answered in the next cycle.
	a_bad_arg_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (!file_valid || request_length <= 32'sd0))
		|=> (done && status == ST_BAD_ARG))
		else $error("bad argument not answered at once");

	// A good word either answers at once or keeps the block busy.
	a_good_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && file_valid && request_length > 32'sd0) |=> (busy || done))
		else $error("accepted word neither answered nor in progress");

	// The block only goes idle with a result on the ports.
	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

endmodule

bind top_down_region_allocator_top tdra_checker u_tdra_checker (.*);
